[rtl/cluster_screen_size_cull_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cluster screen size cull block
// Shared concurrent assertion forms, synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_SCREEN_SIZE_CULL_TOP_MACROS_SVH
`define CLUSTER_SCREEN_SIZE_CULL_TOP_MACROS_SVH

// same-cycle implication
`define CSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg
// Register indexes, reset values, widths and the result mode code.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Z       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJECTION_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCREEN_SIZE  = 3'd7;

    localparam logic signed [17:0] VIEW_DIR_Z_RESET  = 18'sd65536;
    localparam logic [31:0]        SCALE_RESET       = 32'd32768;
    localparam logic [16:0]        MIN_SIZE_RESET    = 17'd66;

    // squared sums stay below 2^68, so roots fit 34 bits
    localparam int SQ_IN_W   = 68;
    localparam int SQ_STEPS  = 34;
    localparam int ROOT_W    = 34;
    localparam int SQ_REM_W  = 38;
    localparam int DIV_STEPS = 32;
    localparam int DIV_REM_W = 35;

    typedef enum logic [1:0] {
        MODE_INSIDE,
        MODE_SCALE,
        MODE_DIV
    } t_mode;

endpackage

[rtl/cluster_screen_size_cull_top.sv]
// ----------------------------------------------------------------------------
// cluster_screen_size_cull_top
// Projected bounding-sphere screen size and render flag, one box per word.
//
//   channel | direction | handshake            | payload
//   box     | in        | i_valid / o_ready    | i_box_min_*, i_box_max_*
//   size    | out       | o_valid / i_ready    | o_screen_size, o_renderable
//   cfg     | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One word per cycle while the output is not stalled; the pipeline holds the 34
// one-digit square-root stages and the 32 one-bit divider stages.
// Synchronous active-low reset clears valid bits and sets configuration to its reset values.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cluster_screen_size_cull_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_screen_size,
    output logic               o_renderable,
    input  logic               i_cfg_we,
    input  logic [csc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NST = 3 + csc_pkg::SQ_STEPS + csc_pkg::DIV_STEPS + 2;
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    // configuration
    logic signed [31:0] r_cam [3];
    logic signed [17:0] r_dir [3];
    logic [31:0]        r_scale;
    logic [16:0]        r_min_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0]   <= '0;
            r_cam[1]   <= '0;
            r_cam[2]   <= '0;
            r_dir[0]   <= '0;
            r_dir[1]   <= '0;
            r_dir[2]   <= csc_pkg::VIEW_DIR_Z_RESET;
            r_scale    <= csc_pkg::SCALE_RESET;
            r_min_size <= csc_pkg::MIN_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csc_pkg::CFG_CAMERA_X:         r_cam[0]   <= i_cfg_data;
                csc_pkg::CFG_CAMERA_Y:         r_cam[1]   <= i_cfg_data;
                csc_pkg::CFG_CAMERA_Z:         r_cam[2]   <= i_cfg_data;
                csc_pkg::CFG_VIEW_DIR_X:       r_dir[0]   <= i_cfg_data[17:0];
                csc_pkg::CFG_VIEW_DIR_Y:       r_dir[1]   <= i_cfg_data[17:0];
                csc_pkg::CFG_VIEW_DIR_Z:       r_dir[2]   <= i_cfg_data[17:0];
                csc_pkg::CFG_PROJECTION_SCALE: r_scale    <= i_cfg_data;
                csc_pkg::CFG_MIN_SCREEN_SIZE:  r_min_size <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // pipeline control: whole pipe moves unless the output word is stalled
    logic           w_en;
    logic [NST-1:0] r_vld;

    assign w_en    = !r_vld[NST-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 1: extents and doubled centre offsets
    logic signed [31:0] w_min [3];
    logic signed [31:0] w_max [3];
    logic [31:0]        r_me [3];
    logic [33:0]        r_md [3];
    logic signed [34:0] r_dd [3];
    logic [31:0]        n_me [3];
    logic [33:0]        n_md [3];
    logic signed [34:0] n_dd [3];

    assign w_min[0] = i_box_min_x;
    assign w_min[1] = i_box_min_y;
    assign w_min[2] = i_box_min_z;
    assign w_max[0] = i_box_max_x;
    assign w_max[1] = i_box_max_y;
    assign w_max[2] = i_box_max_z;

    always_comb begin
        logic signed [32:0] ext;
        for (int a = 0; a < 3; a++) begin
            ext     = 33'(w_max[a]) - 33'(w_min[a]);
            n_me[a] = ext[32] ? 32'(-ext) : ext[31:0];
            n_dd[a] = 35'(w_min[a]) + 35'(w_max[a]) - (35'(r_cam[a]) <<< 1);
            n_md[a] = n_dd[a][34] ? 34'(-n_dd[a]) : n_dd[a][33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_me <= n_me;
            r_md <= n_md;
            r_dd <= n_dd;
        end
    end

    // stage 2: squares and dot terms
    logic [63:0]        r_sq_e [3];
    logic [67:0]        r_sq_d [3];
    logic signed [52:0] r_dotp [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_sq_e[a] <= 64'(r_me[a]) * 64'(r_me[a]);
                r_sq_d[a] <= 68'(r_md[a]) * 68'(r_md[a]);
                r_dotp[a] <= r_dd[a] * r_dir[a];
            end
        end
    end

    // stage 3: sums
    logic [csc_pkg::SQ_IN_W-1:0] r_sum_e;
    logic [csc_pkg::SQ_IN_W-1:0] r_sum_d;
    logic signed [54:0]          r_dot;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum_e <= 68'(r_sq_e[0]) + 68'(r_sq_e[1]) + 68'(r_sq_e[2]);
            r_sum_d <= r_sq_d[0] + r_sq_d[1] + r_sq_d[2];
            r_dot   <= 55'(r_dotp[0]) + 55'(r_dotp[1]) + 55'(r_dotp[2]);
        end
    end

    // square roots, one base-4 digit per stage, both operands side by side
    function automatic logic [csc_pkg::ROOT_W+csc_pkg::SQ_REM_W-1:0] sq_step(
        input logic [csc_pkg::SQ_REM_W-1:0] rem,
        input logic [csc_pkg::ROOT_W-1:0]   root,
        input logic [1:0]                   bits
    );
        logic [csc_pkg::SQ_REM_W-1:0] rem2;
        logic [csc_pkg::SQ_REM_W-1:0] trial;
        rem2  = {rem[csc_pkg::SQ_REM_W-3:0], bits};
        trial = csc_pkg::SQ_REM_W'({root, 2'b01});
        if (rem2 >= trial)
            return {root[csc_pkg::ROOT_W-2:0], 1'b1, rem2 - trial};
        return {root[csc_pkg::ROOT_W-2:0], 1'b0, rem2};
    endfunction

    logic [csc_pkg::SQ_REM_W-1:0] r_sq_rem_e  [csc_pkg::SQ_STEPS];
    logic [csc_pkg::ROOT_W-1:0]   r_sq_root_e [csc_pkg::SQ_STEPS];
    logic [csc_pkg::SQ_IN_W-1:0]  r_sq_v_e    [csc_pkg::SQ_STEPS];
    logic [csc_pkg::SQ_REM_W-1:0] r_sq_rem_d  [csc_pkg::SQ_STEPS];
    logic [csc_pkg::ROOT_W-1:0]   r_sq_root_d [csc_pkg::SQ_STEPS];
    logic [csc_pkg::SQ_IN_W-1:0]  r_sq_v_d    [csc_pkg::SQ_STEPS];
    logic                         r_sq_in     [csc_pkg::SQ_STEPS];
    logic                         r_sq_fwd    [csc_pkg::SQ_STEPS];

    for (genvar s = 0; s < csc_pkg::SQ_STEPS; s++) begin : g_sqrt
        logic [csc_pkg::SQ_REM_W-1:0] w_rem_e, w_rem_d;
        logic [csc_pkg::ROOT_W-1:0]   w_root_e, w_root_d;
        logic [csc_pkg::SQ_IN_W-1:0]  w_v_e, w_v_d;
        logic                         w_in, w_fwd;
        if (s == 0) begin : g_first
            assign w_rem_e  = '0;
            assign w_rem_d  = '0;
            assign w_root_e = '0;
            assign w_root_d = '0;
            assign w_v_e    = r_sum_e;
            assign w_v_d    = r_sum_d;
            assign w_in     = r_sum_d <= r_sum_e;
            assign w_fwd    = r_dot > 55'sd0;
        end else begin : g_next
            assign w_rem_e  = r_sq_rem_e[s-1];
            assign w_rem_d  = r_sq_rem_d[s-1];
            assign w_root_e = r_sq_root_e[s-1];
            assign w_root_d = r_sq_root_d[s-1];
            assign w_v_e    = r_sq_v_e[s-1];
            assign w_v_d    = r_sq_v_d[s-1];
            assign w_in     = r_sq_in[s-1];
            assign w_fwd    = r_sq_fwd[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                {r_sq_root_e[s], r_sq_rem_e[s]} <=
                    sq_step(w_rem_e, w_root_e, w_v_e[csc_pkg::SQ_IN_W-1 -: 2]);
                {r_sq_root_d[s], r_sq_rem_d[s]} <=
                    sq_step(w_rem_d, w_root_d, w_v_d[csc_pkg::SQ_IN_W-1 -: 2]);
                r_sq_v_e[s] <= w_v_e << 2;
                r_sq_v_d[s] <= w_v_d << 2;
                r_sq_in[s]  <= w_in;
                r_sq_fwd[s] <= w_fwd;
            end
        end
    end

    // divider r * 2^32 / d, one quotient bit per stage
    logic [csc_pkg::DIV_REM_W-1:0] r_dv_rem  [csc_pkg::DIV_STEPS];
    logic [csc_pkg::ROOT_W-1:0]    r_dv_d    [csc_pkg::DIV_STEPS];
    logic [31:0]                   r_dv_q    [csc_pkg::DIV_STEPS];
    csc_pkg::t_mode                r_dv_mode [csc_pkg::DIV_STEPS];
    logic                          r_dv_fwd  [csc_pkg::DIV_STEPS];

    for (genvar s = 0; s < csc_pkg::DIV_STEPS; s++) begin : g_div
        logic [csc_pkg::DIV_REM_W-1:0] w_rem, w_rem2;
        logic [csc_pkg::ROOT_W-1:0]    w_d;
        logic [31:0]                   w_q;
        csc_pkg::t_mode                w_mode;
        logic                          w_fwd;
        if (s == 0) begin : g_first
            logic [csc_pkg::ROOT_W-1:0] w_r;
            assign w_r   = r_sq_root_e[csc_pkg::SQ_STEPS-1];
            assign w_d   = r_sq_root_d[csc_pkg::SQ_STEPS-1];
            assign w_rem = csc_pkg::DIV_REM_W'(w_r);
            assign w_q   = '0;
            assign w_fwd = r_sq_fwd[csc_pkg::SQ_STEPS-1];
            always_comb begin
                if (r_sq_in[csc_pkg::SQ_STEPS-1])
                    w_mode = csc_pkg::MODE_INSIDE;
                else if (w_r >= w_d)
                    w_mode = csc_pkg::MODE_SCALE;
                else
                    w_mode = csc_pkg::MODE_DIV;
            end
        end else begin : g_next
            assign w_rem  = r_dv_rem[s-1];
            assign w_d    = r_dv_d[s-1];
            assign w_q    = r_dv_q[s-1];
            assign w_mode = r_dv_mode[s-1];
            assign w_fwd  = r_dv_fwd[s-1];
        end
        assign w_rem2 = {w_rem[csc_pkg::DIV_REM_W-2:0], 1'b0};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_rem2 >= csc_pkg::DIV_REM_W'(w_d)) begin
                    r_dv_rem[s] <= w_rem2 - csc_pkg::DIV_REM_W'(w_d);
                    r_dv_q[s]   <= {w_q[30:0], 1'b1};
                end else begin
                    r_dv_rem[s] <= w_rem2;
                    r_dv_q[s]   <= {w_q[30:0], 1'b0};
                end
                r_dv_d[s]    <= w_d;
                r_dv_mode[s] <= w_mode;
                r_dv_fwd[s]  <= w_fwd;
            end
        end
    end

    // scale multiply
    logic [63:0]    r_prod;
    csc_pkg::t_mode r_mul_mode;
    logic           r_mul_fwd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod     <= 64'(r_dv_q[csc_pkg::DIV_STEPS-1]) * 64'(r_scale);
            r_mul_mode <= r_dv_mode[csc_pkg::DIV_STEPS-1];
            r_mul_fwd  <= r_dv_fwd[csc_pkg::DIV_STEPS-1];
        end
    end

    // output word
    logic [31:0] n_size;

    always_comb begin
        case (r_mul_mode)
            csc_pkg::MODE_INSIDE: n_size = ONE;
            csc_pkg::MODE_SCALE:  n_size = r_scale;
            csc_pkg::MODE_DIV:    n_size = r_prod[63:32];
            default:              n_size = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_screen_size <= n_size;
            o_renderable  <= (n_size > 32'(r_min_size)) && r_mul_fwd;
        end
    end

endmodule

[rtl/csc_checker.sv]
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks on the cluster screen size cull block, bound to the top.
// ----------------------------------------------------------------------------
`include "cluster_screen_size_cull_top_macros.svh"

module csc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_screen_size,
    input logic        o_renderable
);

    logic        w_stall;
    logic        w_rend;
    logic [32:0] w_word;

    assign w_stall = o_valid && !i_ready;
    assign w_rend  = o_valid && o_renderable;
    assign w_word  = {o_screen_size, o_renderable};

    `CSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_valid, "word dropped")
    `CSC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable(w_word), "word changed")
    `CSC_ASSERT_NOW(a_render_size, i_clk, i_rst_n, w_rend, o_screen_size != '0, "zero size")
    `CSC_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready, "ready low when empty")

endmodule

bind cluster_screen_size_cull_top csc_checker u_csc_checker (.*);
